// ----- hw/rtl/cefr_pkg.sv -----
// Shared types, constants and the CRC-32C byte step for the event record framer.
// Used by cefr_front, cefr_cmdq, cefr_back and the top level; depends on nothing.
package cefr_pkg;

  // Largest record (header + payload + sentinel) that may be written.
  localparam int unsigned MAX_RECORD_BYTES = 4194304;
  // A data byte is refused once the payload count exceeds this value.
  localparam logic [31:0] COUNT_LIMIT = 32'(MAX_RECORD_BYTES - 33);

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [63:0] HDR_BYTES   = 64'd16;
  localparam logic [63:0] FRAME_BYTES = 64'd32;

  // Command queue between the front and the back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Step counter of the back: step 0 is the payload byte, steps 1 to 16 the
  // header, steps 17 to 32 the sentinel.
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_HDR_STEP   = 6'd16;
  localparam logic [STEP_W-1:0] FIRST_SENT_STEP = 6'd17;
  localparam logic [STEP_W-1:0] LAST_STEP       = 6'd32;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;
  localparam logic REG_SENTINEL_MAGIC = 1'b0;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        has_byte;
    logic [7:0]  data;
    logic [63:0] byte_off;   // payload byte offset, or record start on an error
    logic [63:0] rec_start;
    logic [63:0] sent_off;
    logic [31:0] count;
    logic [31:0] etype;
    logic [31:0] crc;        // final CRC, already inverted
  } cmd_t;

  // One byte of the reflected CRC-32C.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/cefr_front.sv -----
// Front end of the event record framer: keeps the running CRC, counts and offsets
// and makes commands of accepted data, final and refused items. Depends on cefr_pkg.
module cefr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              has_data,
  input  logic              end_of_event,
  input  logic [31:0]       event_type,
  output logic              cmd_push,
  output cefr_pkg::cmd_t    cmd
);

  logic [31:0] running_crc;
  logic [31:0] payload_count;
  logic [63:0] record_start;
  logic [63:0] payload_offset;   // record_start + 16 + payload_count
  logic        halted;

  logic [31:0] crc_upd;
  logic [31:0] count_inc;
  logic [63:0] poff_inc;
  logic        too_big;

  assign crc_upd   = cefr_pkg::crc_byte(running_crc, data_byte);
  assign count_inc = payload_count + 32'(has_data);
  assign poff_inc  = payload_offset + 64'(has_data);
  assign too_big   = has_data && (payload_count > cefr_pkg::COUNT_LIMIT);

  always_comb begin
    cmd.kind      = cefr_pkg::CMD_BYTE;
    cmd.has_byte  = has_data;
    cmd.data      = data_byte;
    cmd.byte_off  = payload_offset;
    cmd.rec_start = record_start;
    cmd.sent_off  = poff_inc;
    cmd.count     = count_inc;
    cmd.etype     = event_type;
    cmd.crc       = (has_data ? crc_upd : running_crc) ^ cefr_pkg::CRC_ONES;
    cmd_push      = 1'b0;
    if (halted || too_big) begin
      cmd.kind     = cefr_pkg::CMD_ERROR;
      cmd.byte_off = record_start;
      cmd_push     = accept;
    end else if (end_of_event) begin
      cmd.kind = cefr_pkg::CMD_FRAME;
      cmd_push = accept;
    end else if (has_data) begin
      cmd_push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= cefr_pkg::CRC_ONES;
      payload_count  <= 32'd0;
      record_start   <= 64'd0;
      payload_offset <= cefr_pkg::HDR_BYTES;
      halted         <= 1'b0;
    end else if (accept && !halted) begin
      if (too_big) begin
        halted <= 1'b1;
      end else if (end_of_event) begin
        record_start   <= poff_inc + cefr_pkg::HDR_BYTES;
        payload_offset <= poff_inc + cefr_pkg::FRAME_BYTES;
        running_crc    <= cefr_pkg::CRC_ONES;
        payload_count  <= 32'd0;
      end else if (has_data) begin
        running_crc    <= crc_upd;
        payload_count  <= count_inc;
        payload_offset <= poff_inc;
      end
    end
  end

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halted flag dropped without reset");

  // The payload offset always sits 16 bytes past the record start plus the count.
  a_offset_track: assert property (@(posedge clk) disable iff (rst)
    payload_offset == record_start + cefr_pkg::HDR_BYTES + {32'h0, payload_count})
    else $error("payload offset out of step with record start and count");

endmodule

// ----- hw/rtl/cefr_cmdq.sv -----
// Short command queue between the front and the back of the framer.
// Depends on cefr_pkg for the command type and depth.
module cefr_cmdq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cefr_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output cefr_pkg::cmd_t    head
);

  cefr_pkg::cmd_t entries [cefr_pkg::QDEPTH];
  logic [cefr_pkg::QPTR_W-1:0] wr_ptr;
  logic [cefr_pkg::QPTR_W-1:0] rd_ptr;
  logic [cefr_pkg::QPTR_W:0]   fill;

  assign full     = (fill == (cefr_pkg::QPTR_W+1)'(cefr_pkg::QDEPTH));
  assign nonempty = (fill != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("command queue underflow");

endmodule

// ----- hw/rtl/cefr_back.sv -----
// Back end of the framer: expands each command into its result items, one per
// cycle into an output register that is empty or popped. Depends on cefr_pkg.
module cefr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cefr_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  input  logic [63:0]       magic,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic [63:0]       out_offset,
  output logic              event_too_big,
  output logic              is_last
);

  cefr_pkg::cmd_t                cur;
  logic                          cur_valid;
  logic [cefr_pkg::STEP_W-1:0]   step;
  logic                          out_valid;

  logic                          emit;
  logic                          cur_done;
  logic [15:0][7:0]              hdr;
  logic [15:0][7:0]              sen;
  logic [3:0]                    hidx;
  logic [3:0]                    sidx;
  logic [7:0]                    item_byte;
  logic [63:0]                   item_off;
  logic                          item_err;
  logic                          item_last;

  assign empty    = !out_valid;
  assign emit     = cur_valid && (!out_valid || pop);
  assign cur_done = (cur.kind != cefr_pkg::CMD_FRAME) || (step == cefr_pkg::LAST_STEP);
  assign q_pop    = q_valid && (!cur_valid || (emit && cur_done));

  assign hdr  = {cur.crc, 32'h0, cur.etype, cur.count};
  assign sen  = {cur.rec_start, magic};
  assign hidx = 4'(step - 6'd1);
  assign sidx = 4'(step - cefr_pkg::FIRST_SENT_STEP);

  always_comb begin
    item_byte = 8'h00;
    item_off  = cur.byte_off;
    item_err  = 1'b0;
    item_last = 1'b1;
    case (cur.kind)
      cefr_pkg::CMD_ERROR: begin
        item_err = 1'b1;
      end
      cefr_pkg::CMD_BYTE: begin
        item_byte = cur.data;
      end
      cefr_pkg::CMD_FRAME: begin
        if (step == '0) begin
          item_byte = cur.data;
          item_last = 1'b0;
        end else if (step <= cefr_pkg::LAST_HDR_STEP) begin
          item_byte = hdr[hidx];
          item_off  = cur.rec_start + {60'h0, hidx};
          item_last = 1'b0;
        end else begin
          item_byte = sen[sidx];
          item_off  = cur.sent_off + {60'h0, sidx};
          item_last = (step == cefr_pkg::LAST_STEP);
        end
      end
      default: begin
        item_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        step      <= q_cmd.has_byte ? 6'd0 : 6'd1;
      end else if (emit) begin
        if (cur_done) begin
          cur_valid <= 1'b0;
        end else begin
          step <= step + 6'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (emit) begin
      out_byte      <= item_byte;
      out_offset    <= item_off;
      event_too_big <= item_err;
      is_last       <= item_last;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (step <= cefr_pkg::LAST_STEP)) else $error("back step out of range");

  a_error_item: assert property (@(posedge clk) disable iff (rst)
    (emit && cur.kind == cefr_pkg::CMD_ERROR) |=> (!empty && event_too_big && is_last))
    else $error("error command did not produce a final error item");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (q_pop && cur_valid) |-> (emit && cur_done))
    else $error("command loaded over one still being expanded");

endmodule

// ----- hw/rtl/crc32c_event_record_framer_top.sv -----
// Top level of the CRC-32C event record framer: input queue port, result queue
// port and configuration port. Depends on cefr_pkg, cefr_front, cefr_cmdq, cefr_back.
//
//   Port group   Handshake            Moves
//   ----------   ------------------   ------------------------------------------------
//   input        push / full          data_byte, has_data, end_of_event, event_type
//   result       empty / pop          out_byte, out_offset, event_too_big, is_last
//   config       psel/penable/pready  sentinel_magic at byte address 0 (64-bit data)
//
// An item is accepted every cycle unless the command queue is full. A data item
// makes one result item, a final item up to 33, an error one. The back end sends
// one result item per cycle while results are popped, so a final item occupies
// the result side for all of its result items, while the front keeps taking up to
// four commands ahead. The first result item of an item passes through the command
// queue and the back end's current command before reaching the output register.
// Reset is synchronous and active high; it clears the CRC, count, record start,
// the halt flag and the magic register. Either side may stall at any time.
module crc32c_event_record_framer_top (
  input  logic                            clk,
  input  logic                            rst,
  // input item queue
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      data_byte,
  input  logic                            has_data,
  input  logic                            end_of_event,
  input  logic [31:0]                     event_type,
  // result item queue
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_byte,
  output logic [63:0]                     out_offset,
  output logic                            event_too_big,
  output logic                            is_last,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cefr_pkg::PADDR_W-1:0]    paddr,
  input  logic [cefr_pkg::PDATA_W-1:0]    pwdata,
  output logic [cefr_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  logic [63:0]       sentinel_magic;
  logic              accept;
  logic              cmd_push;
  cefr_pkg::cmd_t    front_cmd;
  logic              q_full;
  logic              q_nonempty;
  logic              q_pop;
  cefr_pkg::cmd_t    q_head;

  // The only register decodes on paddr[3]; byte addresses 8 and up read as zero.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == cefr_pkg::REG_SENTINEL_MAGIC) ? sentinel_magic : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sentinel_magic <= 64'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[3] == cefr_pkg::REG_SENTINEL_MAGIC) begin
      sentinel_magic <= pwdata;
    end
  end

  // The input side is held off only while the command queue is full.
  assign full   = q_full;
  assign accept = push && !q_full;

  cefr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .has_data     (has_data),
    .end_of_event (end_of_event),
    .event_type   (event_type),
    .cmd_push     (cmd_push),
    .cmd          (front_cmd)
  );

  cefr_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  cefr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_nonempty),
    .q_cmd         (q_head),
    .q_pop         (q_pop),
    .magic         (sentinel_magic),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .out_offset    (out_offset),
    .event_too_big (event_too_big),
    .is_last       (is_last)
  );

endmodule
